FILE: src/lcdns_pkg.sv
// Shared types, constants and the power-up table for the character-LCD nibble sequencer.
// No dependencies; every other file of the block but lcdns_if refers to it by scoped names.

package lcdns_pkg;

    localparam int COLUMNS = 40;
    localparam int ROWS    = 2;

    localparam int INIT_LEN   = 15;
    localparam int STEP_W     = 4;
    localparam int JOB_WAIT_W = 11;

    localparam logic [JOB_WAIT_W-1:0] WAIT_CLEAR = JOB_WAIT_W'(1520);
    localparam logic [JOB_WAIT_W-1:0] WAIT_CMD   = JOB_WAIT_W'(40);

    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_DISP_BASE  = 8'h08;
    localparam logic [7:0] CMD_HOME_ADDR  = 8'h80;
    localparam logic [1:0] CMD_CGRAM_HIGH = 2'b01;

    localparam logic [2:0] GLYPH_ROW_FIRST = 3'd0;
    localparam logic [2:0] GLYPH_ROW_LAST  = 3'd7;

    typedef enum logic [2:0] {
        REQ_INIT  = 3'd0,
        REQ_CLEAR = 3'd1,
        REQ_DISP  = 3'd2,
        REQ_CURSOR = 3'd3,
        REQ_CHAR  = 3'd4,
        REQ_GLYPH = 3'd5
    } t_req_kind;

    // One byte to be sent as two nibble transfers.
    typedef struct packed {
        logic [7:0]            value;
        logic                  rs;
        logic [JOB_WAIT_W-1:0] wait_us;
    } t_byte_job;

    // A classified request: either the power-up run or a list of one to three bytes.
    typedef struct packed {
        logic                is_init;
        logic [1:0]          nbytes;
        t_byte_job [2:0]     bytes;
    } t_job;

    typedef struct packed {
        logic        strobe_res;
        logic        reg_select;
        logic [3:0]  nibble;
        logic [15:0] wait_after_us;
        logic        last;
    } t_xfer;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Power-up run, one transfer per step; last is filled in by the caller.
    function automatic t_xfer init_xfer(input logic [STEP_W-1:0] idx);
        t_xfer x;
        x = '0;
        x.strobe_res = 1'b1;
        unique case (idx)
            4'd0: begin
                x.strobe_res    = 1'b0;
                x.wait_after_us = 16'd50000;
            end
            4'd1: begin
                x.nibble = 4'h3;
                x.wait_after_us = 16'd10000;
            end
            4'd2: begin
                x.nibble = 4'h3;
                x.wait_after_us = 16'd500;
            end
            4'd3: x.nibble = 4'h3;
            4'd4: x.nibble = 4'h2;
            4'd5: x.nibble = 4'h2;
            4'd6: begin
                x.nibble = 4'h8;
                x.wait_after_us = 16'd50;
            end
            4'd7: x.nibble = 4'h0;
            4'd8: begin
                x.nibble = 4'hE;
                x.wait_after_us = 16'd50;
            end
            4'd9: x.nibble = 4'h0;
            4'd10: begin
                x.nibble = 4'h1;
                x.wait_after_us = 16'd5000;
            end
            4'd11: x.nibble = 4'h0;
            4'd12: begin
                x.nibble = 4'h6;
                x.wait_after_us = 16'd50;
            end
            4'd13: x.nibble = 4'h8;
            4'd14: begin
                x.nibble = 4'h0;
                x.wait_after_us = 16'd50;
            end
            default: x = '0;
        endcase
        return x;
    endfunction

endpackage

FILE: src/lcdns_if.sv
// Valid/ready channel interfaces for requests and nibble transfers.
// Depends on nothing but plain logic types.

interface lcdns_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic       disp_on;
    logic       cursor_on;
    logic       blink_on;
    logic [5:0] column;
    logic [1:0] line;
    logic [7:0] char_byte;
    logic [2:0] glyph_slot;
    logic [2:0] glyph_row;

    modport source (
        output valid, req_type, disp_on, cursor_on, blink_on, column, line,
               char_byte, glyph_slot, glyph_row,
        input  ready
    );
    modport sink (
        input  valid, req_type, disp_on, cursor_on, blink_on, column, line,
               char_byte, glyph_slot, glyph_row,
        output ready
    );
endinterface

interface lcdns_xfer_if;
    logic        valid;
    logic        ready;
    logic        strobe_res;
    logic        reg_select;
    logic [3:0]  nibble;
    logic [15:0] wait_after_us;
    logic        last;

    modport source (
        output valid, strobe_res, reg_select, nibble, wait_after_us, last,
        input  ready
    );
    modport sink (
        input  valid, strobe_res, reg_select, nibble, wait_after_us, last,
        output ready
    );
endinterface

FILE: src/lcdns_front.sv
// Request front end: accepts a request and classifies it into a byte job for the queue.
// Depends on lcdns_pkg and lcdns_req_if.

module lcdns_front (
    lcdns_req_if.sink      i_req,
    input  logic           i_full,
    output logic           o_push,
    output lcdns_pkg::t_job o_job
);

    logic       row_c;
    logic [5:0] col_c;
    logic       known;
    lcdns_pkg::t_byte_job b_data;

    assign i_req.ready = !i_full;

    always_comb begin
        row_c = ({1'b0, i_req.line} >= 3'(lcdns_pkg::ROWS)) ? 1'b0 : i_req.line[0];
        col_c = ({1'b0, i_req.column} >= 7'(lcdns_pkg::COLUMNS)) ? 6'd0 : i_req.column;
    end

    always_comb begin
        b_data.value   = i_req.char_byte;
        b_data.rs      = 1'b1;
        b_data.wait_us = lcdns_pkg::WAIT_CMD;

        o_job   = '0;
        known   = 1'b1;
        unique case (lcdns_pkg::t_req_kind'(i_req.req_type))
            lcdns_pkg::REQ_INIT: begin
                o_job.is_init = 1'b1;
            end
            lcdns_pkg::REQ_CLEAR: begin
                o_job.nbytes   = 2'd1;
                o_job.bytes[0] = '{value: lcdns_pkg::CMD_CLEAR, rs: 1'b0,
                                   wait_us: lcdns_pkg::WAIT_CLEAR};
            end
            lcdns_pkg::REQ_DISP: begin
                o_job.nbytes   = 2'd1;
                o_job.bytes[0] = '{value: lcdns_pkg::CMD_DISP_BASE |
                                          {5'd0, i_req.disp_on, i_req.cursor_on,
                                           i_req.blink_on},
                                   rs: 1'b0, wait_us: lcdns_pkg::WAIT_CMD};
            end
            lcdns_pkg::REQ_CURSOR: begin
                o_job.nbytes   = 2'd1;
                o_job.bytes[0] = '{value: {1'b1, row_c, col_c}, rs: 1'b0,
                                   wait_us: lcdns_pkg::WAIT_CMD};
            end
            lcdns_pkg::REQ_CHAR: begin
                o_job.nbytes   = 2'd1;
                o_job.bytes[0] = b_data;
            end
            lcdns_pkg::REQ_GLYPH: begin
                // The first row is preceded by the glyph-memory address, the last
                // row is followed by a return to the home position.
                if (i_req.glyph_row == lcdns_pkg::GLYPH_ROW_FIRST) begin
                    o_job.nbytes   = 2'd2;
                    o_job.bytes[0] = '{value: {lcdns_pkg::CMD_CGRAM_HIGH, i_req.glyph_slot,
                                               3'b000},
                                       rs: 1'b0, wait_us: lcdns_pkg::WAIT_CMD};
                    o_job.bytes[1] = b_data;
                end else if (i_req.glyph_row == lcdns_pkg::GLYPH_ROW_LAST) begin
                    o_job.nbytes   = 2'd2;
                    o_job.bytes[0] = b_data;
                    o_job.bytes[1] = '{value: lcdns_pkg::CMD_HOME_ADDR, rs: 1'b0,
                                       wait_us: lcdns_pkg::WAIT_CMD};
                end else begin
                    o_job.nbytes   = 2'd1;
                    o_job.bytes[0] = b_data;
                end
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    // Unknown request types are taken and dropped; they cause no transfer.
    assign o_push = i_req.valid && !i_full && known;

endmodule

FILE: src/lcdns_queue.sv
// Two-entry job queue between the request front end and the transfer back end.
// Depends on lcdns_pkg.

module lcdns_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  lcdns_pkg::t_job      i_job,
    input  logic                 i_pop,
    output lcdns_pkg::t_job      o_head,
    output lcdns_pkg::t_q_status o_status
);

    lcdns_pkg::t_job r_mem [2];
    logic       r_wr, n_wr;
    logic       r_rd, n_rd;
    logic [1:0] r_count, n_count;

    always_comb begin
        n_wr    = i_push ? !r_wr : r_wr;
        n_rd    = i_pop  ? !r_rd : r_rd;
        n_count = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_head         = r_mem[r_rd];
    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);

endmodule

FILE: src/lcdns_back.sv
// Back end: steps the head job into an output register, one nibble per cycle unless stalled.
// Depends on lcdns_pkg and lcdns_xfer_if.

module lcdns_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lcdns_pkg::t_job     i_head,
    input  logic                i_empty,
    output logic                o_pop,
    lcdns_xfer_if.source        o_xfer
);

    logic [lcdns_pkg::STEP_W-1:0] r_step, n_step;
    logic [lcdns_pkg::STEP_W-1:0] last_step;
    logic                         r_valid, n_valid;
    lcdns_pkg::t_xfer             r_out, gen;
    lcdns_pkg::t_byte_job         cur;
    logic                         advance;
    logic                         is_last;

    always_comb begin
        unique case (r_step[2:1])
            2'd0:    cur = i_head.bytes[0];
            2'd1:    cur = i_head.bytes[1];
            2'd2:    cur = i_head.bytes[2];
            default: cur = i_head.bytes[0];
        endcase

        last_step = i_head.is_init ? lcdns_pkg::STEP_W'(lcdns_pkg::INIT_LEN - 1)
                                   : ({1'b0, i_head.nbytes, 1'b0} - 4'd1);
        is_last   = (r_step == last_step);

        if (i_head.is_init) begin
            gen = lcdns_pkg::init_xfer(r_step);
        end else begin
            gen.strobe_res    = 1'b1;
            gen.reg_select    = cur.rs;
            // High nibble first; the byte's wait follows the low nibble.
            gen.nibble        = r_step[0] ? cur.value[3:0] : cur.value[7:4];
            gen.wait_after_us = r_step[0] ? {5'd0, cur.wait_us} : 16'd0;
            gen.last          = 1'b0;
        end
        gen.last = is_last;
    end

    assign advance = !r_valid || o_xfer.ready;
    assign o_pop   = advance && !i_empty && is_last;

    always_comb begin
        n_step  = r_step;
        n_valid = r_valid;
        if (advance) begin
            n_valid = !i_empty;
            if (!i_empty) begin
                n_step = is_last ? '0 : r_step + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && !i_empty) begin
            r_out <= gen;
        end
    end

    assign o_xfer.valid         = r_valid;
    assign o_xfer.strobe_res    = r_out.strobe_res;
    assign o_xfer.reg_select    = r_out.reg_select;
    assign o_xfer.nibble        = r_out.nibble;
    assign o_xfer.wait_after_us = r_out.wait_after_us;
    assign o_xfer.last          = r_out.last;

endmodule

FILE: src/char_lcd_nibble_sequencer_core.sv
// Character-LCD 4-bit nibble sequencer, top level.
// Requests arrive on i_req (valid/ready); each is classified by the front end into a job,
// held in a two-entry queue, and expanded by the back end into nibble transfers on o_xfer.
// Every transfer carries strobe, register select, nibble, the wait that must follow it,
// and a last flag on the final transfer of the request.
// With the back end idle, the first transfer of a request is valid once its job has passed
// the queue and the back end's output register. Throughput: one transfer per cycle while
// the receiver is ready, set by the back end's output register. A request gives two transfers
// for clear, display control, set cursor and character write, two or four for a glyph row,
// fifteen for power-up init. Unknown request types are taken and give no transfer.
// The front end keeps taking requests while the queue has room, so a new request can be
// taken while earlier transfers are still waiting on the output.
// When the receiver stalls, the output transfer holds and the queue fills; i_req.ready
// drops once two jobs are waiting.
// Synchronous active-low reset empties the queue and the output register; the block
// takes requests in the first cycle after reset.
// Depends on lcdns_pkg, lcdns_if, lcdns_front, lcdns_queue and lcdns_back.

module char_lcd_nibble_sequencer_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lcdns_req_if.sink    i_req,
    lcdns_xfer_if.source o_xfer
);

    lcdns_pkg::t_job      job_in;
    lcdns_pkg::t_job      job_head;
    lcdns_pkg::t_q_status q_stat;
    logic                 push;
    logic                 pop;

    lcdns_front u_front (
        .i_req  (i_req),
        .i_full (q_stat.full),
        .o_push (push),
        .o_job  (job_in)
    );

    lcdns_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (job_in),
        .i_pop    (pop),
        .o_head   (job_head),
        .o_status (q_stat)
    );

    lcdns_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (job_head),
        .i_empty (q_stat.empty),
        .o_pop   (pop),
        .o_xfer  (o_xfer)
    );

    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty at once");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("job pushed into a full queue");

    a_pop_gives_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (o_xfer.valid && o_xfer.last))
        else $error("job retired without a last transfer on the output");

    a_wait_only_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_xfer.valid && !o_xfer.strobe_res) |->
            (o_xfer.nibble == 4'h0 && !o_xfer.reg_select && !o_xfer.last))
        else $error("wait-only transfer with a nibble, data select or last flag");

endmodule

FILE: tb/sv/tb.sv
// Testbench for the character-LCD nibble sequencer: directed and random requests,
// checked transfer by transfer against a behavioral expansion of each request.
// Depends on lcdns_pkg, lcdns_if and char_lcd_nibble_sequencer_core.
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT = 500000;
    localparam int REPORT_LIMIT = 10;
    localparam int SETTLE_CYCLES = 8;

    // Request codes the block does not define; it must take them and stay silent.
    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;

    localparam logic [7:0] LCD_CLEAR        = 8'h01;
    localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] LCD_DISPLAY_CTRL = 8'h08;
    localparam logic [7:0] LCD_DISPLAY_ON   = 8'h0E;
    localparam logic [7:0] LCD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] LCD_SET_CGRAM    = 8'h40;
    localparam logic [7:0] LCD_SET_DDRAM    = 8'h80;
    localparam logic [7:0] ROW_STRIDE       = 8'h40;
    localparam logic [3:0] WAKE_NIBBLE      = 4'h3;
    localparam logic [3:0] BUS_4BIT_NIBBLE  = 4'h2;
    localparam logic RS_COMMAND = 1'b0;
    localparam logic RS_DATA    = 1'b1;

    localparam logic [15:0] WAIT_POWER_UP = 16'd50000;
    localparam logic [15:0] WAIT_WAKE_1   = 16'd10000;
    localparam logic [15:0] WAIT_WAKE_2   = 16'd500;
    localparam logic [15:0] WAIT_INIT_CMD = 16'd50;
    localparam logic [15:0] WAIT_INIT_CLR = 16'd5000;
    localparam logic [15:0] WAIT_CLEAR_US = 16'd1520;
    localparam logic [15:0] WAIT_CMD_US   = 16'd40;

    typedef struct packed {
        logic [2:0] req_type;
        logic       disp_on;
        logic       cursor_on;
        logic       blink_on;
        logic [5:0] column;
        logic [1:0] line;
        logic [7:0] char_byte;
        logic [2:0] glyph_slot;
        logic [2:0] glyph_row;
    } t_lcd_req;

    localparam int REQ_BITS = $bits(t_lcd_req);

    logic i_clk = 1'b0;
    logic i_rst_n;

    lcdns_req_if  req_if();
    lcdns_xfer_if xfer_if();

    char_lcd_nibble_sequencer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_xfer  (xfer_if)
    );

    always #1 i_clk = ~i_clk;

    lcdns_pkg::t_xfer pending_nibbles[$];
    lcdns_pkg::t_xfer request_run[$];
    int    mismatch_count = 0;
    int    cycle_count = 0;
    int    rx_hold_cycles = 0;
    bit    rx_stalls_on = 1'b1;
    bit    tx_gaps_on = 1'b1;
    int    tx_burst_left = 0;

    // ---------------------------------------------------------------
    // Expected nibble stream for one request
    // ---------------------------------------------------------------
    function automatic void add_nibble(input logic strobe, input logic rs,
                                       input logic [3:0] nib, input logic [15:0] wait_us);
        lcdns_pkg::t_xfer x;
        x.strobe_res    = strobe;
        x.reg_select    = rs;
        x.nibble        = nib;
        x.wait_after_us = wait_us;
        x.last          = 1'b0;
        request_run.push_back(x);
    endfunction

    // A byte goes out high nibble first; only the low nibble carries the wait.
    function automatic void add_lcd_byte(input logic [7:0] value, input logic rs,
                                         input logic [15:0] wait_us);
        add_nibble(1'b1, rs, value[7:4], 16'd0);
        add_nibble(1'b1, rs, value[3:0], wait_us);
    endfunction

    function automatic void expand_request(input t_lcd_req r);
        logic [1:0] ln;
        logic [5:0] col;
        logic [7:0] addr;
        request_run.delete();
        case (r.req_type)
            lcdns_pkg::REQ_INIT: begin
                add_nibble(1'b0, RS_COMMAND, 4'h0, WAIT_POWER_UP);
                add_nibble(1'b1, RS_COMMAND, WAKE_NIBBLE, WAIT_WAKE_1);
                add_nibble(1'b1, RS_COMMAND, WAKE_NIBBLE, WAIT_WAKE_2);
                add_nibble(1'b1, RS_COMMAND, WAKE_NIBBLE, 16'd0);
                add_nibble(1'b1, RS_COMMAND, BUS_4BIT_NIBBLE, 16'd0);
                add_lcd_byte(LCD_FUNCTION_SET, RS_COMMAND, WAIT_INIT_CMD);
                add_lcd_byte(LCD_DISPLAY_ON, RS_COMMAND, WAIT_INIT_CMD);
                add_lcd_byte(LCD_CLEAR, RS_COMMAND, WAIT_INIT_CLR);
                add_lcd_byte(LCD_ENTRY_MODE, RS_COMMAND, WAIT_INIT_CMD);
                add_lcd_byte(LCD_SET_DDRAM, RS_COMMAND, WAIT_INIT_CMD);
            end
            lcdns_pkg::REQ_CLEAR: add_lcd_byte(LCD_CLEAR, RS_COMMAND, WAIT_CLEAR_US);
            lcdns_pkg::REQ_DISP:
                add_lcd_byte(LCD_DISPLAY_CTRL | {5'd0, r.disp_on, r.cursor_on, r.blink_on},
                             RS_COMMAND, WAIT_CMD_US);
            lcdns_pkg::REQ_CURSOR: begin
                ln  = (int'(r.line) >= lcdns_pkg::ROWS) ? 2'd0 : r.line;
                col = (int'(r.column) >= lcdns_pkg::COLUMNS) ? 6'd0 : r.column;
                addr = LCD_SET_DDRAM | ((8'(ln) * ROW_STRIDE + 8'(col)) & 8'h7F);
                add_lcd_byte(addr, RS_COMMAND, WAIT_CMD_US);
            end
            lcdns_pkg::REQ_CHAR: add_lcd_byte(r.char_byte, RS_DATA, WAIT_CMD_US);
            lcdns_pkg::REQ_GLYPH: begin
                if (r.glyph_row == 3'd0)
                    add_lcd_byte(LCD_SET_CGRAM | ((8'(r.glyph_slot) * 8'd8) & 8'h3F),
                                 RS_COMMAND, WAIT_CMD_US);
                add_lcd_byte(r.char_byte, RS_DATA, WAIT_CMD_US);
                if (r.glyph_row == 3'd7)
                    add_lcd_byte(LCD_SET_DDRAM, RS_COMMAND, WAIT_CMD_US);
            end
            default: ;
        endcase
        if (request_run.size() != 0)
            request_run[request_run.size() - 1].last = 1'b1;
        foreach (request_run[i])
            pending_nibbles.push_back(request_run[i]);
    endfunction

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------
    function automatic t_lcd_req random_request();
        t_lcd_req r;
        int pick;
        r = t_lcd_req'(REQ_BITS'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 4)
            r.req_type = lcdns_pkg::REQ_INIT;
        else if (pick < 7)
            r.req_type = (pick == 5) ? REQ_SPARE_A : REQ_SPARE_B;
        else
            r.req_type = 3'($urandom_range(lcdns_pkg::REQ_CLEAR, lcdns_pkg::REQ_GLYPH));
        return r;
    endfunction

    // Called on a rising edge; returns on the edge at which the request is taken.
    task automatic send_request(input t_lcd_req r);
        req_if.valid      <= 1'b1;
        req_if.req_type   <= r.req_type;
        req_if.disp_on    <= r.disp_on;
        req_if.cursor_on  <= r.cursor_on;
        req_if.blink_on   <= r.blink_on;
        req_if.column     <= r.column;
        req_if.line       <= r.line;
        req_if.char_byte  <= r.char_byte;
        req_if.glyph_slot <= r.glyph_slot;
        req_if.glyph_row  <= r.glyph_row;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        expand_request(r);
    endtask

    task automatic idle_sender(input int cycles);
        req_if.valid     <= 1'b0;
        req_if.req_type  <= 3'($urandom);
        req_if.char_byte <= 8'($urandom);
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic pace_sender();
        if (!tx_gaps_on)
            return;
        if (tx_burst_left > 0) begin
            tx_burst_left--;
            return;
        end
        idle_sender($urandom_range(1, 6));
        tx_burst_left = $urandom_range(0, 9);
    endtask

    task automatic send_paced(input t_lcd_req r);
        send_request(r);
        pace_sender();
    endtask

    task automatic wait_for_drain();
        req_if.valid <= 1'b0;
        while (pending_nibbles.size() != 0)
            @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed();
        t_lcd_req r;
        logic [2:0] flags[4] = '{3'b000, 3'b111, 3'b101, 3'b010};
        logic [7:0] cursor_cases[5] = '{8'h00, 8'h67, 8'h68, 8'h85, 8'hFF};
        logic [7:0] char_cases[3] = '{8'h00, 8'hFF, 8'hA5};
        r = random_request();
        r.req_type = lcdns_pkg::REQ_INIT;
        send_paced(r);
        r.req_type = lcdns_pkg::REQ_CLEAR;
        send_paced(r);
        foreach (flags[i]) begin
            r = random_request();
            r.req_type = lcdns_pkg::REQ_DISP;
            {r.disp_on, r.cursor_on, r.blink_on} = flags[i];
            send_paced(r);
        end
        // Each case packs line and column; the last three land out of range.
        foreach (cursor_cases[i]) begin
            r = random_request();
            r.req_type = lcdns_pkg::REQ_CURSOR;
            {r.line, r.column} = cursor_cases[i];
            send_paced(r);
        end
        foreach (char_cases[i]) begin
            r = random_request();
            r.req_type  = lcdns_pkg::REQ_CHAR;
            r.char_byte = char_cases[i];
            send_paced(r);
        end
        r = random_request();
        r.req_type = lcdns_pkg::REQ_GLYPH;
        {r.glyph_slot, r.glyph_row, r.char_byte} = {3'd7, 3'd0, 8'h1F};
        send_paced(r);
        {r.glyph_slot, r.glyph_row, r.char_byte} = {3'd0, 3'd3, 8'hE0};
        send_paced(r);
        {r.glyph_slot, r.glyph_row, r.char_byte} = {3'd5, 3'd7, 8'h0A};
        send_paced(r);
        r.req_type = REQ_SPARE_A;
        send_paced(r);
        r.req_type = REQ_SPARE_B;
        send_paced(r);
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_paced(random_request());
    endtask

    // Whole glyph definitions, with an occasional skipped row or stray request mixed in.
    task automatic test_glyph_definitions(input int glyphs);
        t_lcd_req r;
        logic [2:0] slot;
        repeat (glyphs) begin
            slot = 3'($urandom);
            for (int row = 0; row < 8; row++) begin
                if ($urandom_range(0, 19) == 0)
                    send_paced(random_request());
                if ($urandom_range(0, 29) == 0)
                    continue;
                r = random_request();
                r.req_type   = lcdns_pkg::REQ_GLYPH;
                r.glyph_slot = slot;
                r.glyph_row  = 3'(row);
                send_paced(r);
            end
        end
    endtask

    // The receiver holds off long enough for the queue to fill and stall requests.
    task automatic test_output_stall(input int count);
        tx_gaps_on = 1'b0;
        rx_hold_cycles = 300;
        repeat (count) send_paced(random_request());
        wait_for_drain();
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_full_rate(input int count);
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        repeat (count) send_paced(random_request());
        wait_for_drain();
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    initial begin : main_flow
        i_rst_n          <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.req_type  <= lcdns_pkg::REQ_CLEAR;
        req_if.disp_on   <= 1'b0;
        req_if.cursor_on <= 1'b0;
        req_if.blink_on  <= 1'b0;
        req_if.column    <= 6'd0;
        req_if.line      <= 2'd0;
        req_if.char_byte <= 8'd0;
        req_if.glyph_slot <= 3'd0;
        req_if.glyph_row <= 3'd0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_traffic(150);
        test_glyph_definitions(10);
        test_output_stall(24);
        test_full_rate(50);
        test_random_traffic(150);

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[char_lcd_nibble_sequencer_core] OK");
        else
            $display("[char_lcd_nibble_sequencer_core] ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // Transfer side: stall pattern and checking
    // ---------------------------------------------------------------
    initial begin : rx_pacer
        int run_left;
        int hold_left;
        run_left = 0;
        hold_left = 0;
        xfer_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_cycles != 0) begin
                hold_left = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                xfer_if.ready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
            end else if (rx_stalls_on && $urandom_range(0, 99) < 35) begin
                xfer_if.ready <= 1'b0;
                run_left = $urandom_range(0, 5);
            end else begin
                xfer_if.ready <= 1'b1;
                run_left = $urandom_range(0, 10);
            end
        end
    end

    always @(posedge i_clk) begin
        lcdns_pkg::t_xfer got;
        lcdns_pkg::t_xfer want;
        if (i_rst_n === 1'b1 && xfer_if.valid === 1'b1 && xfer_if.ready === 1'b1) begin
            got.strobe_res    = xfer_if.strobe_res;
            got.reg_select    = xfer_if.reg_select;
            got.nibble        = xfer_if.nibble;
            got.wait_after_us = xfer_if.wait_after_us;
            got.last          = xfer_if.last;
            if (pending_nibbles.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected transfer: strobe %b rs %b nibble %h wait %0d last %b",
                             got.strobe_res, got.reg_select, got.nibble,
                             got.wait_after_us, got.last);
            end else begin
                want = pending_nibbles.pop_front();
                if (got.strobe_res !== want.strobe_res || got.reg_select !== want.reg_select
                        || got.nibble !== want.nibble || got.wait_after_us !== want.wait_after_us
                        || got.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"transfer mismatch: expected strobe %b rs %b nibble %h ",
                                  "wait %0d last %b, got strobe %b rs %b nibble %h wait %0d ",
                                  "last %b"},
                                 want.strobe_res, want.reg_select, want.nibble,
                                 want.wait_after_us, want.last, got.strobe_res,
                                 got.reg_select, got.nibble, got.wait_after_us, got.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[char_lcd_nibble_sequencer_core] ERROR");
            $finish;
        end
    end

endmodule
